/* rtl/core/block_variance_engine_top_assert.svh */
// Assertion macros for the block variance engine.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef BLOCK_VARIANCE_ENGINE_TOP_ASSERT_SVH
`define BLOCK_VARIANCE_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define BVE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define BVE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define BVE_ASSERT(lbl, prop, msg)
`define BVE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/core/bve_pkg.sv */
// Shared constants and types of the block variance engine.
// No dependencies; imported by block_variance_engine_top.
package bve_pkg;

  localparam int unsigned MaxLinePixels = 2048;
  localparam int unsigned MaxChannels   = 3;

  // One accumulator per block column (4 pixels minimum) and channel.
  localparam int unsigned AccDepth = (MaxLinePixels / 4) * MaxChannels;
  localparam int unsigned AccAw    = $clog2(AccDepth);
  localparam int unsigned AccW     = 22;

  localparam int unsigned LineW    = 12;
  localparam int unsigned ColW     = 11;
  localparam int unsigned BlkColW  = 9;
  localparam int unsigned NcolW    = 10;

  typedef enum logic [1:0] {
    CfgLinePixels       = 2'd0,
    CfgBlockWidthLog2   = 2'd1,
    CfgBlockHeightLog2  = 2'd2,
    CfgChannelsPerPixel = 2'd3
  } cfg_reg_e;

  localparam logic [LineW-1:0] LinePixelsRst = LineW'(640);
  localparam logic [1:0]       Log2Rst       = 2'd3;
  localparam logic [1:0]       ChannelsRst   = 2'd1;
  localparam logic [1:0]       Log2Eight     = 2'd3;

  // Item held between the memory read and the write back.
  typedef struct packed {
    logic [AccAw-1:0]   idx;
    logic [15:0]        sq;
    logic               in_range;
    logic               first;
    logic               emit;
    logic               row_done;
    logic [BlkColW-1:0] bc;
    logic [1:0]         chan;
  } s1_t;

endpackage

/* rtl/core/block_variance_engine_top.sv */
// Block variance engine: squared deviations summed per block, one
// accumulator per block column and channel in an on-chip RAM.
// Depends on bve_pkg and block_variance_engine_top_assert.svh.
//
// Usage: samples enter in raster order on the in_* valid/ready channel,
// channels_per_pixel interleaved samples per pixel, each with its block
// mean; frame_start_i clears the position counters before its sample.
// When a block's last sample arrives, one result leaves on the out_*
// channel: the sum shifted right by log2 of the block area, the block
// column, the channel and a row_done flag on the last result of a row.
// Configuration is written through cfg_* (always ready) while idle, which
// the user must keep to; the block does not enforce it. Throughput: one
// sample per cycle while results flow, set by the single read-modify-write
// of the accumulator RAM (read at transfer, written back on leaving
// the read stage, a same-entry write forwarded to the following read).
// Reset clears counters, configuration and pipeline valids; the RAM is not
// cleared since every block starts by loading its accumulator.
// If the receiver stalls, the output register holds its result; samples
// keep flowing until the next result-producing sample sits in the read
// stage, then in_ready_o drops.
`include "block_variance_engine_top_assert.svh"

module block_variance_engine_top import bve_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [LineW-1:0]   cfg_data_i,
  // sample channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         sample_value_i,
  input  logic [7:0]         block_mean_i,
  input  logic               frame_start_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        variance_o,
  output logic [BlkColW-1:0] block_column_o,
  output logic [1:0]         channel_index_o,
  output logic               row_done_o
);

  // ---------------- configuration ----------------
  logic [LineW-1:0] line_pixels_q;
  logic [1:0]       bw_code_q, bh_code_q, chans_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_pixels_q <= LinePixelsRst;
      bw_code_q     <= Log2Rst;
      bh_code_q     <= Log2Rst;
      chans_q       <= ChannelsRst;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgLinePixels:       line_pixels_q <= cfg_data_i;
        CfgBlockWidthLog2:   bw_code_q     <= cfg_data_i[1:0];
        CfgBlockHeightLog2:  bh_code_q     <= cfg_data_i[1:0];
        CfgChannelsPerPixel: chans_q       <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // effective geometry; codes below 2 act as 4
  logic             bw8, bh8;
  logic [1:0]       ch_eff;
  logic [LineW-1:0] lp_eff, limit;
  logic [NcolW-1:0] ncols;
  logic [3:0]       rows;

  always_comb begin
    bw8    = (bw_code_q == Log2Eight);
    bh8    = (bh_code_q == Log2Eight);
    ch_eff = (chans_q == 2'd0) ? 2'd1 : chans_q;
    if (line_pixels_q > LineW'(MaxLinePixels)) begin
      lp_eff = LineW'(MaxLinePixels);
    end else if (line_pixels_q == '0) begin
      lp_eff = LineW'(1);
    end else begin
      lp_eff = line_pixels_q;
    end
    ncols = bw8 ? NcolW'(lp_eff >> 3) : NcolW'(lp_eff >> 2);
    limit = bw8 ? {lp_eff[LineW-1:3], 3'b000} : {lp_eff[LineW-1:2], 2'b00};
    rows  = bh8 ? 4'd8 : 4'd4;
  end

  // ---------------- stage 0: position, address, square ----------------
  logic [ColW-1:0] pix_col_q, pix_col_d;
  logic [1:0]      chan_q, chan_d;
  logic [2:0]      row_q, row_d;

  logic [ColW-1:0]    x0, x;
  logic [1:0]         c0, c;
  logic [2:0]         r0, r;
  logic               in_range, xin_first, xin_last, r_last;
  logic [BlkColW-1:0] bc;
  logic [AccAw-1:0]   idx;
  logic [7:0]         diff;
  logic [15:0]        sq;
  logic               row_done;
  logic [1:0]         c_inc;
  logic [LineW-1:0]   x_inc;
  logic [3:0]         r_inc;
  logic               in_xfer;

  always_comb begin
    x0 = frame_start_i ? '0 : pix_col_q;
    c0 = frame_start_i ? '0 : chan_q;
    r0 = frame_start_i ? '0 : row_q;
    c  = (c0 >= ch_eff) ? 2'd0 : c0;
    r  = ({1'b0, r0} >= rows) ? 3'd0 : r0;
    x  = x0;

    in_range  = ({1'b0, x} < limit);
    bc        = bw8 ? {1'b0, x[ColW-1:3]} : x[ColW-1:2];
    xin_first = bw8 ? (x[2:0] == 3'd0) : (x[1:0] == 2'd0);
    xin_last  = bw8 ? (&x[2:0]) : (&x[1:0]);
    r_last    = ({1'b0, r} == rows - 4'd1);
    idx       = AccAw'(bc) * AccAw'(ch_eff) + AccAw'(c);
    diff      = (sample_value_i >= block_mean_i) ? sample_value_i - block_mean_i
                                                 : block_mean_i - sample_value_i;
    sq        = 16'(diff) * 16'(diff);
    row_done  = ({1'b0, bc} == ncols - NcolW'(1)) && (c == ch_eff - 2'd1);

    // raster walk: channel, then pixel, then line within the block row
    c_inc = c + 2'd1;
    x_inc = {1'b0, x} + LineW'(1);
    r_inc = {1'b0, r} + 4'd1;
    chan_d    = c_inc;
    pix_col_d = x;
    row_d     = r;
    if (c_inc >= ch_eff) begin
      chan_d = 2'd0;
      if (x_inc >= lp_eff) begin
        pix_col_d = '0;
        row_d     = (r_inc >= rows) ? 3'd0 : r_inc[2:0];
      end else begin
        pix_col_d = x_inc[ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_col_q <= '0;
      chan_q    <= '0;
      row_q     <= '0;
    end else if (in_xfer) begin
      pix_col_q <= pix_col_d;
      chan_q    <= chan_d;
      row_q     <= row_d;
    end
  end

  // ---------------- stage 1: accumulate and write back ----------------
  logic              s1_valid_q, s1_valid_d;
  s1_t               s1_q;
  logic [AccW-1:0]   rdata_q;
  logic              wb_valid_q;
  logic [AccAw-1:0]  wb_idx_q;
  logic [AccW-1:0]   wb_acc_q;
  logic [AccW-1:0]   acc_base, acc;
  logic [2:0]        area_log2;
  logic              s1_adv, mem_we, out_load;
  logic              out_valid_q, out_valid_d;

  logic [AccW-1:0] acc_mem [AccDepth];

  always_comb begin
    // the entry written at the edge of this item's read comes from wb_*
    acc_base  = (wb_valid_q && (wb_idx_q == s1_q.idx)) ? wb_acc_q : rdata_q;
    acc       = s1_q.first ? AccW'(s1_q.sq) : acc_base + AccW'(s1_q.sq);
    area_log2 = 3'd4 + {2'b00, bw8} + {2'b00, bh8};

    s1_adv     = s1_valid_q && (!s1_q.emit || !out_valid_q || out_ready_i);
    in_ready_o = !s1_valid_q || s1_adv;
    in_xfer    = in_valid_i && in_ready_o;
    mem_we     = s1_adv && s1_q.in_range;
    out_load   = s1_adv && s1_q.emit;

    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rdata_q <= acc_mem[idx];
    end
    if (mem_we) begin
      acc_mem[s1_q.idx] <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q.idx      <= idx;
      s1_q.sq       <= sq;
      s1_q.in_range <= in_range;
      s1_q.first    <= (r == 3'd0) && xin_first;
      s1_q.emit     <= in_range && xin_last && r_last;
      s1_q.row_done <= row_done;
      s1_q.bc       <= bc;
      s1_q.chan     <= c;
    end
    if (mem_we) begin
      wb_idx_q <= s1_q.idx;
      wb_acc_q <= acc;
    end
    if (out_load) begin
      variance_o      <= 16'(acc >> area_log2);
      block_column_o  <= s1_q.bc;
      channel_index_o <= s1_q.chan;
      row_done_o      <= s1_q.row_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      wb_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (mem_we) begin
        wb_valid_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------- assertions ----------------
  `BVE_ASSERT(a_empty_stage_ready, !s1_valid_q |-> in_ready_o, "read stage empty but not ready")
  `BVE_ASSERT(a_no_overwrite, (out_valid_q && !out_ready_i) |-> !out_load, "held result overwritten")
  `BVE_ASSERT(a_emit_in_range, (s1_valid_q && s1_q.emit) |-> s1_q.in_range, "result outside the blocks")
  `BVE_ASSERT(a_xfer_fills_stage, in_xfer |=> s1_valid_q, "transferred sample lost")
  `BVE_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (!out_valid_o && in_ready_o), "busy in reset")

endmodule
